### src/gcsp_pkg.sv
// gcsp_pkg: shared constants, command word type and helpers for the
// greedy correlation-score pruning block. No dependencies.
package gcsp_pkg;

    localparam int NUM_VARIANTS = 65536;
    localparam int KEEP_DEPTH   = (NUM_VARIANTS < 65536) ? NUM_VARIANTS : 65536;
    localparam int KEEP_AW      = $clog2(KEEP_DEPTH);

    localparam int IDX_W   = 16;
    localparam int CORR_W  = 16;
    localparam int SQ_W    = 31;
    localparam int SCORE_W = 48;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] OPC_ENTRY  = 2'd0;
    localparam logic [1:0] OPC_FINISH = 2'd1;
    localparam logic [1:0] OPC_WRITE  = 2'd2;
    localparam logic [1:0] OPC_RSVD   = 2'd3;

    localparam int  PADDR_W       = 4;
    localparam logic REG_THRESHOLD = 1'b0;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] index;
        logic             in_range;
        logic [SQ_W-1:0]  sq;
        logic             keep_value;
    } cmd_t;

    function automatic logic in_bitmap(input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] lim;
        lim = (IDX_W+1)'(KEEP_DEPTH);
        return ({1'b0, idx} < lim);
    endfunction

endpackage

### src/gcsp_front.sv
// gcsp_front: accepts input words, classifies them and squares the correlation,
// then holds them in a short queue for the back end. Depends on gcsp_pkg.
module gcsp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic [gcsp_pkg::IDX_W-1:0]    variant_index,
    input  logic [gcsp_pkg::IDX_W-1:0]    neighbour_index,
    input  logic signed [gcsp_pkg::CORR_W-1:0] correlation,
    input  logic                          keep_value,
    input  logic                          clearing,
    output logic                          head_valid,
    output gcsp_pkg::cmd_t                head,
    input  logic                          pop
);

    gcsp_pkg::cmd_t                   queue_reg [gcsp_pkg::QUEUE_DEPTH];
    logic [gcsp_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [gcsp_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [gcsp_pkg::QUEUE_AW:0]      count_reg;
    logic [gcsp_pkg::QUEUE_AW:0]      count_next;
    gcsp_pkg::cmd_t                   cmd;
    logic [gcsp_pkg::CORR_W:0]        mag;
    logic [2*gcsp_pkg::CORR_W+1:0]    sq_full;
    logic                             full;
    logic                             push;

    assign full     = (count_reg == (gcsp_pkg::QUEUE_AW+1)'(gcsp_pkg::QUEUE_DEPTH));
    assign in_stall = full || clearing;
    assign push     = in_valid && !in_stall && (opcode != gcsp_pkg::OPC_RSVD);

    always_comb
    begin
        mag = correlation[gcsp_pkg::CORR_W-1]
            ? ((gcsp_pkg::CORR_W+1)'(0) - {correlation[gcsp_pkg::CORR_W-1], correlation})
            : {1'b0, correlation};
        sq_full        = mag * mag;
        cmd.op         = opcode;
        cmd.index      = (opcode == gcsp_pkg::OPC_ENTRY) ? neighbour_index : variant_index;
        cmd.in_range   = gcsp_pkg::in_bitmap(cmd.index);
        cmd.sq         = sq_full[gcsp_pkg::SQ_W-1:0];
        cmd.keep_value = keep_value;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cmd;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head       = queue_reg[rd_ptr_reg];

endmodule

### src/gcsp_back.sv
// gcsp_back: keep-bit memory with its clearing pass, score accumulation,
// threshold decision and result register. Depends on gcsp_pkg.
module gcsp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  gcsp_pkg::cmd_t                head,
    output logic                          pop,
    output logic                          clearing,
    input  logic [gcsp_pkg::SCORE_W-1:0]  threshold,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gcsp_pkg::IDX_W-1:0]    variant_index_out,
    output logic                          kept,
    output logic [gcsp_pkg::SCORE_W-1:0]  score
);

    logic                             keep_mem [gcsp_pkg::KEEP_DEPTH];

    logic                             clr_active_reg;
    logic [gcsp_pkg::KEEP_AW-1:0]     clr_addr_reg;

    logic                             p1_valid_reg;
    gcsp_pkg::cmd_t                   p1_cmd_reg;
    logic                             rd_bit_reg;
    logic                             fwd_hit_reg;
    logic                             fwd_val_reg;

    logic [gcsp_pkg::SCORE_W-1:0]     score_reg;
    logic [gcsp_pkg::SCORE_W-1:0]     score_next;

    logic                             out_valid_reg;
    logic [gcsp_pkg::IDX_W-1:0]       out_index_reg;
    logic                             out_kept_reg;
    logic [gcsp_pkg::SCORE_W-1:0]     out_score_reg;

    logic                             out_load_ok;
    logic                             p1_fire;
    logic                             p1_bit;
    logic                             pass;
    logic [gcsp_pkg::SCORE_W:0]       sum;
    logic                             item_we;
    logic                             mem_we;
    logic [gcsp_pkg::KEEP_AW-1:0]     mem_waddr;
    logic                             mem_wdata;
    logic [gcsp_pkg::KEEP_AW-1:0]     raddr;

    assign clearing    = clr_active_reg;
    assign out_load_ok = !out_valid_reg || !out_stall;
    assign p1_fire     = p1_valid_reg
                         && ((p1_cmd_reg.op != gcsp_pkg::OPC_FINISH) || out_load_ok);
    assign pop         = head_valid && !clr_active_reg && (!p1_valid_reg || p1_fire);
    assign raddr       = head.index[gcsp_pkg::KEEP_AW-1:0];

    assign p1_bit = p1_cmd_reg.in_range && (fwd_hit_reg ? fwd_val_reg : rd_bit_reg);
    assign pass   = (score_reg <= threshold);
    assign sum    = {1'b0, score_reg} + (gcsp_pkg::SCORE_W+1)'(p1_cmd_reg.sq);

    // Only a finish that keeps, or a keep-bit write, touches the bitmap.
    assign item_we = p1_fire && p1_cmd_reg.in_range
                     && ((p1_cmd_reg.op == gcsp_pkg::OPC_WRITE)
                         || ((p1_cmd_reg.op == gcsp_pkg::OPC_FINISH) && pass));

    always_comb
    begin
        if (clr_active_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = 1'b0;
        end
        else
        begin
            mem_we    = item_we;
            mem_waddr = p1_cmd_reg.index[gcsp_pkg::KEEP_AW-1:0];
            mem_wdata = (p1_cmd_reg.op == gcsp_pkg::OPC_WRITE) ? p1_cmd_reg.keep_value : 1'b1;
        end
    end

    always_comb
    begin
        score_next = score_reg;
        if (p1_fire)
        begin
            unique case (p1_cmd_reg.op)
                gcsp_pkg::OPC_ENTRY:
                begin
                    if (p1_bit)
                    begin
                        score_next = sum[gcsp_pkg::SCORE_W]
                                     ? gcsp_pkg::SCORE_MAX : sum[gcsp_pkg::SCORE_W-1:0];
                    end
                end
                gcsp_pkg::OPC_FINISH:
                begin
                    score_next = '0;
                end
                default:
                begin
                    score_next = score_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            keep_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_bit_reg <= keep_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            p1_cmd_reg  <= head;
            fwd_hit_reg <= item_we && (mem_waddr == raddr);
            fwd_val_reg <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_fire && (p1_cmd_reg.op == gcsp_pkg::OPC_FINISH))
        begin
            out_index_reg <= p1_cmd_reg.index;
            out_kept_reg  <= pass;
            out_score_reg <= score_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            p1_valid_reg   <= 1'b0;
            score_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == gcsp_pkg::KEEP_AW'(gcsp_pkg::KEEP_DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end

            if (pop)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_fire)
            begin
                p1_valid_reg <= 1'b0;
            end

            score_reg <= score_next;

            if (p1_fire && (p1_cmd_reg.op == gcsp_pkg::OPC_FINISH))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign variant_index_out = out_index_reg;
    assign kept              = out_kept_reg;
    assign score             = out_score_reg;

endmodule

### src/greedy_corr_score_pruning.sv
// greedy_corr_score_pruning: top level with the threshold register port.
// Instantiates gcsp_front and gcsp_back; depends on gcsp_pkg.

// Sustains one input word per cycle: entries, finishes and keep-bit writes each take a
// single pass through the keep-bit memory read port and the score adder; only a stalled
// result register or the clearing pass holds the back end. A finish word's result goes
// through the queue, p1 and result registers. After reset the keep bitmap is swept
// clear one bit per cycle, KEEP_DEPTH (65536) bits, in_stall high; the threshold
// register can be written meanwhile at byte address 0 (64-bit data, low 48 bits used).
module greedy_corr_score_pruning (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gcsp_pkg::PADDR_W-1:0]  paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic [gcsp_pkg::IDX_W-1:0]    variant_index,
    input  logic [gcsp_pkg::IDX_W-1:0]    neighbour_index,
    input  logic signed [gcsp_pkg::CORR_W-1:0] correlation,
    input  logic                          keep_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gcsp_pkg::IDX_W-1:0]    variant_index_out,
    output logic                          kept,
    output logic [gcsp_pkg::SCORE_W-1:0]  score
);

    logic [gcsp_pkg::SCORE_W-1:0]  threshold_reg;
    logic                          reg_sel;
    logic                          clearing;
    logic                          head_valid;
    gcsp_pkg::cmd_t                head;
    logic                          pop;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[3] == gcsp_pkg::REG_THRESHOLD);
    assign prdata  = reg_sel ? {{(64-gcsp_pkg::SCORE_W){1'b0}}, threshold_reg} : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            threshold_reg <= pwdata[gcsp_pkg::SCORE_W-1:0];
        end
    end

    gcsp_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .variant_index   (variant_index),
        .neighbour_index (neighbour_index),
        .correlation     (correlation),
        .keep_value      (keep_value),
        .clearing        (clearing),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop)
    );

    gcsp_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head_valid        (head_valid),
        .head              (head),
        .pop               (pop),
        .clearing          (clearing),
        .threshold         (threshold_reg),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .variant_index_out (variant_index_out),
        .kept              (kept),
        .score             (score)
    );

`ifndef SYNTHESIS
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (in_stall && !head_valid))
        else $error("word can enter while keep bitmap is being cleared");

    a_kept_within_threshold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kept) |-> (score <= threshold_reg))
        else $error("variant kept with score above threshold");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !out_valid)
        else $error("result produced during clearing pass");
`endif

endmodule
